@@ hw/rtl/rfoe_pkg.sv @@
// shared types and constants of the rectangle fill and outline engine
package rfoe_pkg;

    // frame store geometry, both sizes powers of two
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int DIM_W      = 9;

    // signed pixel coordinate after mapping: magnitude below 2^32 plus room for +1
    localparam int PIX_W      = 34;

    localparam int COLOR_W    = 24;
    localparam logic [COLOR_W-1:0] WHITE = 24'hFF_FFFF;

    typedef enum logic [1:0] {
        CMD_FILL    = 2'd0,
        CMD_BLEND   = 2'd1,
        CMD_OUTLINE = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_X_ORIGIN = 3'd0,
        CFG_X_SCALE  = 3'd1,
        CFG_Y_ORIGIN = 3'd2,
        CFG_Y_SCALE  = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_HEIGHT   = 3'd5
    } t_cfg_idx;

endpackage

@@ hw/rtl/rfoe_map.sv @@
// world coordinate to pixel mapper: (v - origin) * scale >> 32, truncated toward zero
module rfoe_map (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [31:0]                 i_value,
    input  logic signed [31:0]                 i_origin,
    input  logic        [31:0]                 i_scale,
    output logic                               o_done,
    output logic signed [rfoe_pkg::PIX_W-1:0]  o_pixel
);
    import rfoe_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_SUM,
        M_OUT
    } t_mstate;

    t_mstate            r_state;
    logic               r_neg;
    logic        [32:0] r_mag;
    logic        [31:0] r_scale;
    logic        [47:0] r_lo;
    logic        [48:0] r_hi;
    logic        [32:0] r_q;

    logic signed [32:0] diff;
    logic        [47:0] lo_prod;
    logic        [48:0] hi_prod;
    logic        [64:0] sum;
    logic        [PIX_W-1:0] q_ext;

    assign diff    = $signed({i_value[31], i_value}) - $signed({i_origin[31], i_origin});
    // magnitude split in two halves so each product stays within 17 x 32
    assign lo_prod = r_mag[15:0] * r_scale;
    assign hi_prod = r_mag[32:16] * r_scale;
    assign sum     = {r_hi, 16'd0} + {17'd0, r_lo};
    assign q_ext   = {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_neg   <= diff[32];
                        r_mag   <= diff[32] ? 33'(-diff) : 33'(diff);
                        r_scale <= i_scale;
                        r_state <= M_LO;
                    end
                end
                M_LO: begin
                    r_lo    <= lo_prod;
                    r_state <= M_HI;
                end
                M_HI: begin
                    r_hi    <= hi_prod;
                    r_state <= M_SUM;
                end
                M_SUM: begin
                    r_q     <= sum[64:32];
                    r_state <= M_OUT;
                end
                M_OUT: begin
                    o_pixel <= r_neg ? $signed(-q_ext) : $signed(q_ext);
                    o_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

endmodule

@@ hw/rtl/rectangle_fill_outline_engine.sv @@
// top level: command sequencer, configuration registers and the frame store
// After reset the frame store is swept to white, one pixel per cycle, and the block
// stays busy and takes no command until the sweep ends; configuration writes are
// taken at any time. A pixel read passes ST_RD_ADDR and ST_RD_DATA before the result strobe.
// A draw first maps the left, right, bottom and top edges in turn through a single
// shared coordinate mapper, then scans every pixel of the clipped bounding box,
// outlines included, and finishes through ST_DRAIN and ST_FIN (ST_FIN alone for an
// empty box): the single read-modify-write port of the frame store sets one pixel per cycle.
// Results come as a one-cycle strobe on o_done and cannot be held off.
module rectangle_fill_outline_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [31:0] i_left_edge,
    input  logic [31:0] i_right_edge,
    input  logic [31:0] i_bottom_edge,
    input  logic [31:0] i_top_edge,
    input  logic [7:0]  i_read_column,
    input  logic [7:0]  i_read_row,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic        o_result_kind,
    output logic [7:0]  o_pixel_red,
    output logic [7:0]  o_pixel_green,
    output logic [7:0]  o_pixel_blue,
    output logic [16:0] o_pixels_written
);
    import rfoe_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP_GO,
        ST_MAP_WAIT,
        ST_ADJ,
        ST_BOUND,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN,
        ST_RD_ADDR,
        ST_RD_DATA
    } t_state;

    // configuration
    logic signed [31:0] r_x_origin, r_y_origin;
    logic        [31:0] r_x_scale, r_y_scale;
    logic  [DIM_W-1:0]  r_img_w, r_img_h;

    // command
    t_state             r_state;
    t_cmd               r_cmd;
    logic [COLOR_W-1:0] r_col;
    logic signed [31:0] r_edge [4];
    logic [7:0]         r_rd_col, r_rd_row;
    logic [1:0]         r_idx;
    logic signed [PIX_W-1:0] r_px [4];
    logic [DIM_W-1:0]   r_lo_i, r_hi_i, r_lo_j, r_hi_j;
    logic [DIM_W-1:0]   r_mk_l, r_mk_r, r_mk_b, r_mk_t;
    logic               r_mk_l_v, r_mk_r_v, r_mk_b_v, r_mk_t_v;
    logic [DIM_W-1:0]   r_i, r_j;
    logic [16:0]        r_count;
    logic [ADDR_W-1:0]  r_clr_addr;

    // write stage of the pixel pipeline
    logic               r_p1_valid;
    logic               r_p1_en;
    logic [ADDR_W-1:0]  r_p1_addr;

    // frame store
    logic [COLOR_W-1:0] mem [MAX_WIDTH*MAX_HEIGHT];
    logic [COLOR_W-1:0] r_rdata;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa, mem_ra, scan_addr;
    logic [COLOR_W-1:0] mem_wd, blend;

    logic [DIM_W-1:0]   eff_w, eff_h, row_flip, n_i, n_j;
    logic signed [PIX_W-1:0] w_s, h_s, n_right, n_top, right_m1, top_m1;
    logic               accept, pix_en, j_last, i_last, rd_in_range;
    logic               map_done;
    logic signed [PIX_W-1:0] map_pixel;
    logic signed [31:0] map_value, map_origin;
    logic        [31:0] map_scale;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic signed [PIX_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic signed [PIX_W-1:0] lim_s;
        lim_s = $signed(PIX_W'(lim));
        if (v < 0)
            return '0;
        else if (v > lim_s)
            return lim;
        else
            return v[DIM_W-1:0];
    endfunction

    function automatic logic in_dim(input logic signed [PIX_W-1:0] v);
        return v[PIX_W-1:DIM_W] == '0;
    endfunction

    // image size in use: zero acts as one, oversize as the store size
    always_comb begin
        if (r_img_w == '0)
            eff_w = DIM_W'(1);
        else if (r_img_w > DIM_W'(MAX_WIDTH))
            eff_w = DIM_W'(MAX_WIDTH);
        else
            eff_w = r_img_w;
        if (r_img_h == '0)
            eff_h = DIM_W'(1);
        else if (r_img_h > DIM_W'(MAX_HEIGHT))
            eff_h = DIM_W'(MAX_HEIGHT);
        else
            eff_h = r_img_h;
    end

    assign w_s = $signed(PIX_W'(eff_w));
    assign h_s = $signed(PIX_W'(eff_h));

    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= '0;
            r_x_scale  <= 32'd65536;
            r_y_origin <= '0;
            r_y_scale  <= 32'd65536;
            r_img_w    <= DIM_W'(256);
            r_img_h    <= DIM_W'(256);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_X_ORIGIN: r_x_origin <= $signed(i_cfg_data);
                CFG_X_SCALE:  r_x_scale  <= i_cfg_data;
                CFG_Y_ORIGIN: r_y_origin <= $signed(i_cfg_data);
                CFG_Y_SCALE:  r_y_scale  <= i_cfg_data;
                CFG_WIDTH:    r_img_w    <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:   r_img_h    <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // edges 0 and 1 are x, 2 and 3 are y
    assign map_value  = r_edge[r_idx];
    assign map_origin = r_idx[1] ? r_y_origin : r_x_origin;
    assign map_scale  = r_idx[1] ? r_y_scale  : r_x_scale;

    rfoe_map u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == ST_MAP_GO),
        .i_value  (map_value),
        .i_origin (map_origin),
        .i_scale  (map_scale),
        .o_done   (map_done),
        .o_pixel  (map_pixel)
    );

    // single-pixel widening for fills and blends, one-pixel growth for outlines
    always_comb begin
        n_right = r_px[1];
        n_top   = r_px[3];
        if ((r_cmd == CMD_OUTLINE || r_px[0] == r_px[1]) && (r_px[1] + 1 < w_s))
            n_right = r_px[1] + 1;
        if ((r_cmd == CMD_OUTLINE || r_px[2] == r_px[3]) && (r_px[3] + 1 < h_s))
            n_top = r_px[3] + 1;
    end

    assign right_m1 = r_px[1] - 1;
    assign top_m1   = r_px[3] - 1;

    // scan of the clipped box, columns outer, rows inner
    assign row_flip  = eff_h - DIM_W'(1) - r_j;
    assign scan_addr = {row_flip[ROW_W-1:0], r_i[COL_W-1:0]};
    assign n_i       = r_i + DIM_W'(1);
    assign n_j       = r_j + DIM_W'(1);
    assign j_last    = (n_j >= r_hi_j);
    assign i_last    = (n_i >= r_hi_i);
    assign pix_en    = (r_cmd != CMD_OUTLINE)
                    || (r_mk_l_v && r_i == r_mk_l) || (r_mk_r_v && r_i == r_mk_r)
                    || (r_mk_b_v && r_j == r_mk_b) || (r_mk_t_v && r_j == r_mk_t);

    assign rd_in_range = ({1'b0, r_rd_col} < eff_w) && ({1'b0, r_rd_row} < eff_h);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            blend[c*8 +: 8] = (r_rdata[c*8 +: 8] < r_col[c*8 +: 8]) ?
                              r_rdata[c*8 +: 8] : r_col[c*8 +: 8];
        end
    end

    // frame store ports
    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = WHITE;
        end else begin
            mem_we = r_p1_valid && r_p1_en;
            mem_wa = r_p1_addr;
            mem_wd = (r_cmd == CMD_FILL) ? r_col : blend;
        end
    end

    assign mem_ra = (r_state == ST_SCAN) ? scan_addr : {r_rd_row, r_rd_col};

    always_ff @(posedge i_clk) begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        r_p1_en   <= pix_en;
        r_p1_addr <= scan_addr;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_p1_valid <= 1'b0;
            o_done     <= 1'b0;
        end else begin
            o_done     <= 1'b0;
            r_p1_valid <= 1'b0;
            if (r_p1_valid && r_p1_en)
                r_count <= r_count + 17'd1;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == '1)
                        r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd     <= t_cmd'(i_command);
                        r_col     <= {i_red, i_green, i_blue};
                        r_edge[0] <= $signed(i_left_edge);
                        r_edge[1] <= $signed(i_right_edge);
                        r_edge[2] <= $signed(i_bottom_edge);
                        r_edge[3] <= $signed(i_top_edge);
                        r_rd_col  <= i_read_column;
                        r_rd_row  <= i_read_row;
                        r_idx     <= '0;
                        r_count   <= '0;
                        r_state   <= (t_cmd'(i_command) == CMD_READ) ? ST_RD_ADDR : ST_MAP_GO;
                    end
                end
                ST_MAP_GO: r_state <= ST_MAP_WAIT;
                ST_MAP_WAIT: begin
                    if (map_done) begin
                        r_px[r_idx] <= map_pixel;
                        r_idx       <= r_idx + 2'd1;
                        r_state     <= (r_idx == 2'd3) ? ST_ADJ : ST_MAP_GO;
                    end
                end
                ST_ADJ: begin
                    r_px[1] <= n_right;
                    r_px[3] <= n_top;
                    r_state <= ST_BOUND;
                end
                ST_BOUND: begin
                    r_lo_i   <= clamp_dim(r_px[0], eff_w);
                    r_hi_i   <= clamp_dim(r_px[1], eff_w);
                    r_lo_j   <= clamp_dim(r_px[2], eff_h);
                    r_hi_j   <= clamp_dim(r_px[3], eff_h);
                    r_mk_l   <= r_px[0][DIM_W-1:0];
                    r_mk_r   <= right_m1[DIM_W-1:0];
                    r_mk_b   <= r_px[2][DIM_W-1:0];
                    r_mk_t   <= top_m1[DIM_W-1:0];
                    r_mk_l_v <= in_dim(r_px[0]);
                    r_mk_r_v <= in_dim(right_m1);
                    r_mk_b_v <= in_dim(r_px[2]);
                    r_mk_t_v <= in_dim(top_m1);
                    r_state  <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_i <= r_lo_i;
                    r_j <= r_lo_j;
                    if (r_hi_i <= r_lo_i || r_hi_j <= r_lo_j)
                        r_state <= ST_FIN;
                    else
                        r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    r_p1_valid <= 1'b1;
                    if (j_last) begin
                        r_j <= r_lo_j;
                        r_i <= n_i;
                        if (i_last)
                            r_state <= ST_DRAIN;
                    end else begin
                        r_j <= n_j;
                    end
                end
                ST_DRAIN: r_state <= ST_FIN;
                ST_FIN: begin
                    o_done           <= 1'b1;
                    o_result_kind    <= 1'b0;
                    o_pixel_red      <= '0;
                    o_pixel_green    <= '0;
                    o_pixel_blue     <= '0;
                    o_pixels_written <= r_count;
                    r_state          <= ST_IDLE;
                end
                ST_RD_ADDR: r_state <= ST_RD_DATA;
                ST_RD_DATA: begin
                    o_done           <= 1'b1;
                    o_result_kind    <= 1'b1;
                    o_pixel_red      <= rd_in_range ? r_rdata[23:16] : 8'd0;
                    o_pixel_green    <= rd_in_range ? r_rdata[15:8]  : 8'd0;
                    o_pixel_blue     <= rd_in_range ? r_rdata[7:0]   : 8'd0;
                    o_pixels_written <= '0;
                    r_state          <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // no frame store write may be left over once the block reports idle
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mem_we)
        else $error("frame store written while idle");

    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_i < r_hi_i && r_j < r_hi_j && r_i < eff_w && r_j < eff_h))
        else $error("scan outside clipped box");

    a_draw_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result_kind) |->
            (o_pixel_red == 8'd0 && o_pixel_green == 8'd0 && o_pixel_blue == 8'd0))
        else $error("draw result carries color");

    a_read_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result_kind) |-> (o_pixels_written == '0))
        else $error("read result carries a pixel count");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

endmodule

@@ verif/rfoe_checker.sv @@
// checker for the rectangle engine: frame store model, result prediction and comparison
`timescale 1ns / 100ps

module rfoe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [31:0] i_left_edge,
    input  logic [31:0] i_right_edge,
    input  logic [31:0] i_bottom_edge,
    input  logic [31:0] i_top_edge,
    input  logic [7:0]  i_read_column,
    input  logic [7:0]  i_read_row,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_done,
    input  logic        i_result_kind,
    input  logic [7:0]  i_pixel_red,
    input  logic [7:0]  i_pixel_green,
    input  logic [7:0]  i_pixel_blue,
    input  logic [16:0] i_pixels_written,
    output int          o_pending,
    output int          o_failures
);
    import rfoe_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [16:0] written;
    } t_completion;

    logic [COLOR_W-1:0] frame_model [MAX_WIDTH*MAX_HEIGHT];
    logic signed [31:0] x_org;
    logic signed [31:0] y_org;
    logic [31:0]        x_scl;
    logic [31:0]        y_scl;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;

    t_completion awaited_completions [$];
    t_completion got;
    t_completion want;

    // exact product of offset and scale, shifted right by 32 and truncated toward zero
    function automatic longint map_edge(logic [31:0] v, logic signed [31:0] origin,
                                        logic [31:0] scale);
        longint      d;
        logic [63:0] mag;
        logic [63:0] prod;
        d    = longint'($signed(v)) - longint'(origin);
        mag  = (d < 0) ? 64'(-d) : 64'(d);
        prod = mag * {32'b0, scale};
        return (d < 0) ? -longint'(prod[63:32]) : longint'(prod[63:32]);
    endfunction

    function automatic longint eff_dim(logic [DIM_W-1:0] v, int cap);
        if (v == 0) return 1;
        if (int'(v) > cap) return cap;
        return longint'(v);
    endfunction

    function automatic logic [COLOR_W-1:0] darker_of(logic [COLOR_W-1:0] a,
                                                     logic [COLOR_W-1:0] b);
        logic [COLOR_W-1:0] m;
        int s;
        for (s = 0; s < COLOR_W; s += 8)
            m[s +: 8] = (a[s +: 8] < b[s +: 8]) ? a[s +: 8] : b[s +: 8];
        return m;
    endfunction

    // applies one command to the frame model and returns its completion
    function automatic t_completion render_command(t_cmd cmd, logic [COLOR_W-1:0] rgb,
                                                   logic [31:0] l_edge, logic [31:0] r_edge,
                                                   logic [31:0] b_edge, logic [31:0] t_edge,
                                                   logic [7:0] col, logic [7:0] row);
        t_completion res;
        longint w, h, left, right, bottom, top;
        longint lo_i, hi_i, lo_j, hi_j, i, j;
        int addr;
        res = '0;
        w = eff_dim(width_reg, MAX_WIDTH);
        h = eff_dim(height_reg, MAX_HEIGHT);
        if (cmd == CMD_READ) begin
            res.kind = 1'b1;
            if (longint'(col) < w && longint'(row) < h)
                {res.red, res.green, res.blue} = frame_model[int'(row) * MAX_WIDTH + int'(col)];
            return res;
        end
        left   = map_edge(l_edge, x_org, x_scl);
        right  = map_edge(r_edge, x_org, x_scl);
        bottom = map_edge(b_edge, y_org, y_scl);
        top    = map_edge(t_edge, y_org, y_scl);
        if (cmd == CMD_OUTLINE) begin
            if (right + 1 < w) right++;
            if (top + 1 < h) top++;
        end else begin
            // one pixel wide fills and blends grow by one where they fit
            if (left == right && right + 1 < w) right++;
            if (bottom == top && top + 1 < h) top++;
        end
        lo_i = (left < 0) ? 0 : left;
        hi_i = (right > w) ? w : right;
        lo_j = (bottom < 0) ? 0 : bottom;
        hi_j = (top > h) ? h : top;
        for (i = lo_i; i < hi_i; i++) begin
            for (j = lo_j; j < hi_j; j++) begin
                // outline shape comes from the unclipped bounds
                if (cmd != CMD_OUTLINE || i == left || i == right - 1 ||
                    j == bottom || j == top - 1) begin
                    addr = int'((h - 1 - j) * MAX_WIDTH + i);
                    frame_model[addr] = (cmd == CMD_FILL) ? rgb
                                                          : darker_of(frame_model[addr], rgb);
                    res.written++;
                end
            end
        end
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            o_failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_WIDTH * MAX_HEIGHT; k++) frame_model[k] = WHITE;
            x_org      = '0;
            y_org      = '0;
            x_scl      = 32'h0001_0000;
            y_scl      = 32'h0001_0000;
            width_reg  = 9'd256;
            height_reg = 9'd256;
            awaited_completions.delete();
            o_failures = 0;
            o_pending <= 0;
        end else begin
            // register write beat
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_X_ORIGIN: x_org      = i_cfg_data;
                    CFG_X_SCALE:  x_scl      = i_cfg_data;
                    CFG_Y_ORIGIN: y_org      = i_cfg_data;
                    CFG_Y_SCALE:  y_scl      = i_cfg_data;
                    CFG_WIDTH:    width_reg  = i_cfg_data[DIM_W-1:0];
                    CFG_HEIGHT:   height_reg = i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_done) begin
                got = '{i_result_kind, i_pixel_red, i_pixel_green, i_pixel_blue,
                        i_pixels_written};
                if (awaited_completions.size() == 0) begin
                    $error("result strobe with no command outstanding");
                    o_failures++;
                end else begin
                    want = awaited_completions.pop_front();
                    check_field("result_kind", want.kind, got.kind);
                    check_field("pixel_red", want.red, got.red);
                    check_field("pixel_green", want.green, got.green);
                    check_field("pixel_blue", want.blue, got.blue);
                    check_field("pixels_written", want.written, got.written);
                end
            end
            // command beat: predicted against the store as it stands now
            if (i_start && !i_busy)
                awaited_completions.push_back(render_command(t_cmd'(i_command),
                    {i_red, i_green, i_blue}, i_left_edge, i_right_edge, i_bottom_edge,
                    i_top_edge, i_read_column, i_read_row));
            o_pending <= awaited_completions.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
// testbench top for the rectangle engine: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;
    import rfoe_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_500_000;
    localparam logic [2:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [2:0] CFG_UNMAPPED_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_start          = 1'b0;
    logic        o_busy;
    logic [1:0]  i_command        = '0;
    logic [7:0]  i_red            = '0;
    logic [7:0]  i_green          = '0;
    logic [7:0]  i_blue           = '0;
    logic [31:0] i_left_edge      = '0;
    logic [31:0] i_right_edge     = '0;
    logic [31:0] i_bottom_edge    = '0;
    logic [31:0] i_top_edge       = '0;
    logic [7:0]  i_read_column    = '0;
    logic [7:0]  i_read_row       = '0;
    logic        i_cfg_valid      = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index      = '0;
    logic [31:0] i_cfg_data       = '0;
    logic        o_done;
    logic        o_result_kind;
    logic [7:0]  o_pixel_red;
    logic [7:0]  o_pixel_green;
    logic [7:0]  o_pixel_blue;
    logic [16:0] o_pixels_written;

    int          pending;
    int          failures;
    int unsigned cycle_count = 0;

    // settings as last programmed, used only to aim random rectangles and reads at the image
    logic [31:0] cur_xo = '0;
    logic [31:0] cur_xs = 32'h0001_0000;
    logic [31:0] cur_yo = '0;
    logic [31:0] cur_ys = 32'h0001_0000;
    int          cur_w  = 256;
    int          cur_h  = 256;
    int          last_l = 0;
    int          last_b = 0;
    bit          no_idle = 1'b0;

    rectangle_fill_outline_engine uut (.*);

    rfoe_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_busy           (o_busy),
        .i_command        (i_command),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_left_edge      (i_left_edge),
        .i_right_edge     (i_right_edge),
        .i_bottom_edge    (i_bottom_edge),
        .i_top_edge       (i_top_edge),
        .i_read_column    (i_read_column),
        .i_read_row       (i_read_row),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_done           (o_done),
        .i_result_kind    (o_result_kind),
        .i_pixel_red      (o_pixel_red),
        .i_pixel_green    (o_pixel_green),
        .i_pixel_blue     (o_pixel_blue),
        .i_pixels_written (o_pixels_written),
        .o_pending        (pending),
        .o_failures       (failures)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    function automatic logic [31:0] fx(int p);
        return p <<< 16;
    endfunction

    function automatic logic [7:0] clamp8(int v);
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // world coordinate landing on or next to pixel p, random when the scale is below 16384
    function automatic logic [31:0] world_at(int p, logic [31:0] org, logic [31:0] scl);
        longint num;
        longint frac;
        if (scl < 32'd16384) return $urandom;
        frac = longint'($urandom);
        num  = (longint'(p) <<< 32) + ((p < 0) ? -frac : frac);
        return org + 32'(num / longint'(scl));
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 3))
            0:       return 32'h0001_0000;
            1:       return 32'h0000_8000;
            2:       return 32'h0002_0000;
            default: return $urandom_range(16384, 262144);
        endcase
    endfunction

    function automatic logic [8:0] pick_dim();
        case ($urandom_range(0, 5))
            0:       return 9'd256;
            1:       return $urandom_range(1, 16);
            2:       return 9'd0;
            3:       return $urandom_range(257, 511);
            default: return $urandom_range(1, 256);
        endcase
    endfunction

    // raises start with the fields and holds until the beat is taken
    task automatic issue(input t_cmd cmd, input logic [23:0] rgb,
                         input logic [31:0] le, input logic [31:0] re,
                         input logic [31:0] be, input logic [31:0] te,
                         input logic [7:0] col, input logic [7:0] row);
        int gap;
        i_start       <= 1'b1;
        i_command     <= cmd;
        {i_red, i_green, i_blue} <= rgb;
        i_left_edge   <= le;
        i_right_edge  <= re;
        i_bottom_edge <= be;
        i_top_edge    <= te;
        i_read_column <= col;
        i_read_row    <= row;
        do @(posedge i_clk); while (o_busy);
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 29) == 0) begin
            i_start <= 1'b0;
            do @(posedge i_clk); while (pending != 0);
        end else if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // waits for the block to drain, then writes every register
    task automatic program_regs(input logic [31:0] xo, input logic [31:0] xs,
                                input logic [31:0] yo, input logic [31:0] ys,
                                input logic [8:0] wd, input logic [8:0] ht);
        logic [31:0] junk;
        junk = $urandom;
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        write_reg(CFG_X_ORIGIN, xo);
        write_reg(CFG_X_SCALE, xs);
        write_reg(CFG_Y_ORIGIN, yo);
        write_reg(CFG_Y_SCALE, ys);
        write_reg(CFG_WIDTH, {junk[31:9], wd});
        write_reg(CFG_HEIGHT, {junk[22:0], ht});
        write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO, $urandom);
        i_cfg_valid <= 1'b0;
        cur_xo = xo;
        cur_xs = xs;
        cur_yo = yo;
        cur_ys = ys;
        cur_w  = (wd == 0) ? 1 : (wd > 256) ? 256 : wd;
        cur_h  = (ht == 0) ? 1 : (ht > 256) ? 256 : ht;
    endtask

    task automatic random_item();
        t_cmd        cmd;
        logic [31:0] le, re, be, te, swap;
        logic [23:0] rgb;
        logic [7:0]  col, row;
        int          pick;
        pick = $urandom_range(0, 99);
        cmd  = (pick < 25) ? CMD_FILL : (pick < 45) ? CMD_BLEND :
               (pick < 65) ? CMD_OUTLINE : CMD_READ;
        rgb  = $urandom;
        col  = $urandom;
        row  = $urandom;
        le   = $urandom;
        re   = $urandom;
        be   = $urandom;
        te   = $urandom;
        if (cmd == CMD_READ) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                // around the last rectangle drawn
                col = clamp8(last_l + int'($urandom_range(0, 11)) - 1);
                row = clamp8(cur_h - 1 - (last_b + int'($urandom_range(0, 11)) - 1));
            end else if (pick < 8) begin
                col = $urandom_range(0, cur_w - 1);
                row = $urandom_range(0, cur_h - 1);
            end
        end else if ($urandom_range(0, 19) == 0) begin
            // raw edges, x reversed so the box stays at most one column wide
            if ($signed(le) < $signed(re)) begin
                swap = le;
                le   = re;
                re   = swap;
            end
        end else begin
            last_l = int'($urandom_range(0, cur_w + 10)) - 6;
            last_b = int'($urandom_range(0, cur_h + 10)) - 6;
            le = world_at(last_l, cur_xo, cur_xs);
            re = world_at(last_l + int'($urandom_range(0, 12)) - 2, cur_xo, cur_xs);
            be = world_at(last_b, cur_yo, cur_ys);
            te = world_at(last_b + int'($urandom_range(0, 12)) - 2, cur_yo, cur_ys);
        end
        issue(cmd, rgb, le, re, be, te, col, row);
    endtask

    initial begin : stimulus
        logic [31:0] xo, yo;
        int ph, n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset settings: 65536 world units per pixel
        issue(CMD_READ, 24'h000000, '0, '0, '0, '0, 8'd0, 8'd0);
        issue(CMD_READ, 24'hFFFFFF, '1, '1, '1, '1, 8'd255, 8'd255);
        issue(CMD_FILL, 24'h123456, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 8'd0, 8'd0);
        issue(CMD_READ, 24'h0, '0, '0, '0, '0, 8'd0, 8'd0);
        issue(CMD_READ, 24'h0, '0, '0, '0, '0, 8'd255, 8'd128);
        issue(CMD_BLEND, 24'h00FF80, fx(10), fx(20), fx(5), fx(9), 8'd0, 8'd0);
        issue(CMD_READ, 24'h0, '0, '0, '0, '0, 8'd12, 8'd249);
        // single pixel grows in both directions
        issue(CMD_FILL, 24'hFFFFFF, fx(3) + 32'h8000, fx(3) + 32'hC000,
              fx(7) + 32'd1, fx(7) + 32'd1, 8'd0, 8'd0);
        // one pixel wide at the right border cannot grow
        issue(CMD_FILL, 24'h000000, fx(255), fx(255), fx(0), fx(4), 8'd0, 8'd0);
        issue(CMD_OUTLINE, 24'h000000, fx(30), fx(40), fx(50), fx(60), 8'd0, 8'd0);
        issue(CMD_READ, 24'h0, '0, '0, '0, '0, 8'd30, 8'd200);
        issue(CMD_READ, 24'h0, '0, '0, '0, '0, 8'd35, 8'd200);
        issue(CMD_FILL, 24'hABCDEF, fx(20), fx(10), fx(5), fx(9), 8'd0, 8'd0);
        issue(CMD_FILL, 24'h00FF00, fx(-5), fx(3), fx(-2), fx(2), 8'd0, 8'd0);
        issue(CMD_OUTLINE, 24'h0000FF, fx(-4), fx(5), fx(250), fx(300), 8'd0, 8'd0);
        issue(CMD_BLEND, 24'hFF00FF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 8'd0, 8'd0);
        // outline edges far outside the image: box swept, nothing drawn
        issue(CMD_OUTLINE, 24'h000000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 8'd0, 8'd0);
        // negative fractions truncate toward zero
        issue(CMD_FILL, 24'h3C3C3C, 32'hFFFF_8000, 32'h0001_8000,
              32'hFFFE_8000, 32'h0002_8000, 8'd0, 8'd0);
        issue(CMD_READ, 24'h0, '0, '0, '0, '0, 8'd0, 8'd255);
        issue(CMD_READ, 24'h0, '0, '0, '0, '0, 8'd0, 8'd254);

        // extreme settings
        program_regs(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 9'd0, 9'h1FF);
        repeat (20) random_item();
        program_regs(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 9'd256, 9'd1);
        repeat (20) random_item();

        for (ph = 0; ph < 10; ph++) begin
            xo = ($urandom_range(0, 3) == 0) ? 32'h0 : ($urandom & 32'h1FFF_FFFF) - 32'h1000_0000;
            yo = ($urandom_range(0, 3) == 0) ? 32'h0 : ($urandom & 32'h1FFF_FFFF) - 32'h1000_0000;
            program_regs(xo, pick_scale(), yo, pick_scale(), pick_dim(), pick_dim());
            for (n = 0; n < 90; n++) begin
                if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
                random_item();
            end
        end

        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (64) @(posedge i_clk);
        if (failures == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/rfoe_pkg.sv
hw/rtl/rfoe_map.sv
hw/rtl/rectangle_fill_outline_engine.sv
verif/rfoe_checker.sv
verif/testbench.sv
